/* design/keyframe_position_interpolator_macros.svh */
// Assertion macros shared by the interpolator RTL.
`ifndef KEYFRAME_POSITION_INTERPOLATOR_MACROS_SVH
`define KEYFRAME_POSITION_INTERPOLATOR_MACROS_SVH

// Same-cycle implication, checked on i_clk outside reset.
`define KPI_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("kpi: check failed");

// Next-cycle implication, checked on i_clk outside reset.
`define KPI_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("kpi: check failed");

`endif

/* design/kpi_pkg.sv */
package kpi_pkg;

    localparam int unsigned BLEND_FRAC = 16;
    localparam logic [16:0] BLEND_ONE  = 17'h10000;
    localparam logic [16:0] BLEND_ZERO = 17'h00000;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef struct packed {
        logic               func;
        logic [5:0]         key_index;
        logic [23:0]        key_time;
        logic signed [31:0] key_x;
        logic signed [31:0] key_y;
        logic signed [31:0] key_z;
        logic [23:0]        query_time;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic [5:0]         segment;
        logic [16:0]        blend;
    } t_out_item;

    // One keyframe as held in the table
    typedef struct packed {
        logic [23:0]        tstamp;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } t_key;

endpackage

/* design/kpi_ram.sv */
module kpi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* design/kpi_div.sv */
// Restoring divider: quotient = floor(num * 2^BLEND_FRAC / den), num < den.
module kpi_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [23:0] i_num,
    input  logic [23:0] i_den,
    output logic        o_done,
    output logic [15:0] o_quo
);

    localparam int CW = $clog2(kpi_pkg::BLEND_FRAC + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [23:0]   r_rem;
    logic [23:0]   r_den;
    logic [15:0]   r_quo;
    logic [24:0]   shifted;
    logic          ge;

    assign shifted = {r_rem, 1'b0};
    assign ge      = shifted >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(kpi_pkg::BLEND_FRAC - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Remainder stays below the divisor, so it always fits 24 bits
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num;
            r_den <= i_den;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= ge ? 24'(shifted - {1'b0, r_den}) : shifted[23:0];
            r_quo <= {r_quo[14:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

/* design/kpi_lerp.sv */
// Three-stage lerp: a + floor((b - a) * blend / 2^16), wrapped to 32 bits.
module kpi_lerp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [31:0] i_a,
    input  logic signed [31:0] i_b,
    input  logic [16:0]        i_blend,
    output logic               o_done,
    output logic signed [31:0] o_res
);

    logic               r_v1;
    logic               r_v2;
    logic               r_v3;
    logic signed [31:0] r_a1;
    logic signed [31:0] r_a2;
    logic signed [32:0] r_diff;
    logic [16:0]        r_blend;
    logic signed [50:0] r_prod;
    logic signed [31:0] r_res;
    logic signed [17:0] blend_s;

    assign blend_s = $signed({1'b0, r_blend});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_start;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a1    <= i_a;
        r_diff  <= $signed({i_b[31], i_b}) - $signed({i_a[31], i_a});
        r_blend <= i_blend;
        r_a2    <= r_a1;
        r_prod  <= r_diff * blend_s;
        // arithmetic shift of the product floors toward minus infinity
        r_res   <= r_a2 + $signed(r_prod[47:16]);
    end

    assign o_done = r_v3;
    assign o_res  = r_res;

endmodule

/* design/keyframe_position_interpolator.sv */
// Query path from transfer to result valid: the search reads and compares keys in turn,
// then the divider forms the blend factor and the multiplier runs once per component.
// A saturated factor skips the divider; a zero-length segment or a single key skips both
// the divider and the multiplier. A keyframe write gives no result.
// Throughput: one item at a time; input stalls from transfer until the result is loaded.
// Synchronous reset: key_count = 1, no result pending; table contents kept.
module keyframe_position_interpolator #(
    parameter int KEYS = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  kpi_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output kpi_pkg::t_out_item  o_out_data,
    input  logic                i_cfg_we,
    input  logic [6:0]          i_cfg_data
);

    `include "keyframe_position_interpolator_macros.svh"

    localparam int AW = $clog2(KEYS);

    localparam logic [1:0] COMP_X = 2'd0;
    localparam logic [1:0] COMP_Y = 2'd1;
    localparam logic [1:0] COMP_Z = 2'd2;

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_SRCH_RD  = 9'b000000010,
        S_SRCH_CMP = 9'b000000100,
        S_RD0      = 9'b000001000,
        S_LD0      = 9'b000010000,
        S_DIV      = 9'b000100000,
        S_MUL      = 9'b001000000,
        S_MUL_WAIT = 9'b010000000,
        S_OUT      = 9'b100000000
    } t_state;

    t_state             r_state;
    t_state             n_state;
    logic [6:0]         r_count;
    logic [23:0]        r_q;
    logic [AW-1:0]      r_last;
    logic [AW-1:0]      r_idx;
    logic               r_single;
    kpi_pkg::t_key      r_ka;
    kpi_pkg::t_key      r_kb;
    logic [16:0]        r_blend;
    logic [1:0]         r_comp;
    logic signed [31:0] r_rx;
    logic signed [31:0] r_ry;
    logic signed [31:0] r_rz;
    logic               r_out_valid;
    kpi_pkg::t_out_item r_out;

    logic               in_acc;
    logic               is_query;
    logic               wr_en;
    logic [AW-1:0]      last_v;
    logic [AW-1:0]      idx_inc;
    logic [AW-1:0]      rd_addr;
    kpi_pkg::t_key      wr_key;
    kpi_pkg::t_key      rd_key;
    logic               srch_stop;
    logic               ld_hold;
    logic               ld_zero;
    logic               ld_one;
    logic               div_start;
    logic               div_done;
    logic [15:0]        div_quo;
    logic               lerp_done;
    logic signed [31:0] lerp_res;
    logic signed [31:0] lerp_a;
    logic signed [31:0] lerp_b;
    logic               out_free;
    logic               single_out;

    assign in_acc   = i_in_valid && (r_state == S_IDLE);
    assign is_query = i_in_data.func == kpi_pkg::FUNC_QUERY;
    assign wr_en    = in_acc && (i_in_data.func == kpi_pkg::FUNC_WRITE)
                      && (int'(i_in_data.key_index) < KEYS);
    assign idx_inc  = r_idx + 1'b1;
    assign out_free = !r_out_valid || !i_out_stall;

    // Clamp the key count to 1..KEYS and keep the last valid index
    always_comb begin
        if (r_count == 7'd0) begin
            last_v = '0;
        end else if (int'(r_count) > KEYS) begin
            last_v = AW'(KEYS - 1);
        end else begin
            last_v = AW'(r_count - 7'd1);
        end
    end

    assign wr_key.tstamp = i_in_data.key_time;
    assign wr_key.x      = i_in_data.key_x;
    assign wr_key.y      = i_in_data.key_y;
    assign wr_key.z      = i_in_data.key_z;

    assign rd_addr = (r_state == S_SRCH_RD) ? idx_inc : r_idx;

    kpi_ram #(
        .WIDTH ($bits(kpi_pkg::t_key)),
        .DEPTH (KEYS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (AW'(i_in_data.key_index)),
        .i_wdata (wr_key),
        .i_raddr (rd_addr),
        .o_rdata (rd_key)
    );

    // Search ends at the first later key past the query, or at the last segment
    assign srch_stop = (r_q < rd_key.tstamp) || (idx_inc == r_last);

    assign ld_hold   = r_single || (rd_key.tstamp >= r_kb.tstamp);
    assign ld_zero   = r_q <= rd_key.tstamp;
    assign ld_one    = r_q >= r_kb.tstamp;
    assign div_start = (r_state == S_LD0) && !ld_hold && !ld_zero && !ld_one;

    kpi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_q - rd_key.tstamp),
        .i_den   (r_kb.tstamp - rd_key.tstamp),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    always_comb begin
        unique case (r_comp)
            COMP_X: begin
                lerp_a = r_ka.x;
                lerp_b = r_kb.x;
            end
            COMP_Y: begin
                lerp_a = r_ka.y;
                lerp_b = r_kb.y;
            end
            default: begin
                lerp_a = r_ka.z;
                lerp_b = r_kb.z;
            end
        endcase
    end

    kpi_lerp u_lerp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_MUL),
        .i_a     (lerp_a),
        .i_b     (lerp_b),
        .i_blend (r_blend),
        .o_done  (lerp_done),
        .o_res   (lerp_res)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && is_query) begin
                    n_state = (last_v == '0) ? S_RD0 : S_SRCH_RD;
                end
            end
            S_SRCH_RD:  n_state = S_SRCH_CMP;
            S_SRCH_CMP: n_state = srch_stop ? S_RD0 : S_SRCH_RD;
            S_RD0:      n_state = S_LD0;
            S_LD0: begin
                priority if (ld_hold) begin
                    n_state = S_OUT;
                end else if (ld_zero || ld_one) begin
                    n_state = S_MUL;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV:      n_state = div_done ? S_MUL : S_DIV;
            S_MUL:      n_state = S_MUL_WAIT;
            S_MUL_WAIT: begin
                if (lerp_done) begin
                    n_state = (r_comp == COMP_Z) ? S_OUT : S_MUL;
                end
            end
            S_OUT:      n_state = out_free ? S_IDLE : S_OUT;
            default:    n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= 7'd1;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_count <= i_cfg_data;
            end
            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_q      <= i_in_data.query_time;
                r_last   <= last_v;
                r_single <= last_v == '0;
                r_idx    <= '0;
            end
            S_SRCH_CMP: begin
                // hold the later key of the candidate segment
                r_kb <= rd_key;
                if (!srch_stop) begin
                    r_idx <= idx_inc;
                end
            end
            S_LD0: begin
                r_ka   <= rd_key;
                r_comp <= COMP_X;
                priority if (ld_hold) begin
                    r_rx    <= rd_key.x;
                    r_ry    <= rd_key.y;
                    r_rz    <= rd_key.z;
                    r_blend <= kpi_pkg::BLEND_ZERO;
                end else if (ld_zero) begin
                    r_blend <= kpi_pkg::BLEND_ZERO;
                end else if (ld_one) begin
                    r_blend <= kpi_pkg::BLEND_ONE;
                end else begin
                    r_blend <= r_blend;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    r_blend <= {1'b0, div_quo};
                end
            end
            S_MUL_WAIT: begin
                if (lerp_done) begin
                    unique case (r_comp)
                        COMP_X:  r_rx <= lerp_res;
                        COMP_Y:  r_ry <= lerp_res;
                        default: r_rz <= lerp_res;
                    endcase
                    r_comp <= r_comp + 2'd1;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    r_out.out_x   <= r_rx;
                    r_out.out_y   <= r_ry;
                    r_out.out_z   <= r_rz;
                    r_out.segment <= 6'(r_idx);
                    r_out.blend   <= r_blend;
                end
            end
            default: begin
                r_q <= r_q;
            end
        endcase
    end

    assign o_in_stall  = r_state != S_IDLE;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign single_out = (r_state == S_OUT) && (r_blend == kpi_pkg::BLEND_ZERO)
                        && (r_idx == '0);

    `KPI_ASSERT_NOW(a_div_done_in_div, div_done, r_state == S_DIV)
    `KPI_ASSERT_NOW(a_lerp_done_in_wait, lerp_done, r_state == S_MUL_WAIT)
    `KPI_ASSERT_NOW(a_search_in_range, r_state == S_SRCH_CMP, r_idx < r_last)
    `KPI_ASSERT_NOW(a_blend_range, r_out_valid, r_out.blend <= kpi_pkg::BLEND_ONE)
    `KPI_ASSERT_NEXT(a_single_key, (r_state == S_LD0) && r_single, single_out)

endmodule
